[design/dot_map_to_custom_glyph_renderer_top_macros.svh]
// Assertion macros for the dot map glyph renderer checker.
// No dependencies; included by the checker file.
`ifndef DOT_MAP_TO_CUSTOM_GLYPH_RENDERER_TOP_MACROS_SVH
`define DOT_MAP_TO_CUSTOM_GLYPH_RENDERER_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define DMCG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DMCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/dmcg_pkg.sv]
// Shared types, codes and helpers of the dot map glyph renderer.
// No dependencies; used by every other file of the block but the macro header.
`default_nettype none

package dmcg_pkg;

    localparam int DOT_WIDTH = 5;
    localparam int CELL_BITS = DOT_WIDTH * 8;

    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [6:0] CGRAM_BASE  = 7'h40;
    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [2:0] SLOT_MASK   = 3'h7;
    localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    localparam logic OP_BLANK = 1'b0;
    localparam logic OP_GLYPH = 1'b1;

    typedef enum logic [1:0] {
        CMD_SET_DOT   = 2'd0,
        CMD_CLEAR_DOT = 2'd1,
        CMD_RENDER    = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } dmcg_cmd_t;

    typedef struct packed {
        dmcg_cmd_t   cmd;
        logic [3:0]  dot_row;
        logic [6:0]  dot_col;
    } dmcg_in_t;

    typedef struct packed {
        logic                 op_kind;
        logic [7:0]           cursor_command;
        logic [6:0]           cgram_command;
        logic [CELL_BITS-1:0] glyph_bits;
        logic [7:0]           char_code;
        logic                 last;
    } dmcg_out_t;

    typedef struct packed {
        logic clear_all;
        logic rd_en;
        logic wr_en;
    } dmcg_store_ctl_t;

    // column bytes of one cell (byte i = dot column i) to glyph rows
    function automatic logic [CELL_BITS-1:0] transpose_cell(
        input logic [CELL_BITS-1:0] word
    );
        logic [CELL_BITS-1:0] g;
        g = '0;
        for (int gr = 0; gr < 8; gr++) begin
            for (int i = 0; i < DOT_WIDTH; i++) begin
                g[DOT_WIDTH*gr + DOT_WIDTH - 1 - i] = word[8*i + gr];
            end
        end
        return g;
    endfunction

endpackage

`default_nettype wire

[design/dmcg_cell_store.sv]
// Cell store: one 40-bit word per display cell, with per-cell valid flags.
// Depends on dmcg_pkg; instantiated by the top level.
`default_nettype none

module dmcg_cell_store #(
    parameter int CELLS = 32,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire dmcg_pkg::dmcg_store_ctl_t      ctl,
    input  wire logic [AW-1:0]                  rd_addr,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic [dmcg_pkg::CELL_BITS-1:0] wr_data,
    output logic      [dmcg_pkg::CELL_BITS-1:0] rd_data
);

    logic [dmcg_pkg::CELL_BITS-1:0] mem [CELLS];
    logic [dmcg_pkg::CELL_BITS-1:0] rd_word_reg;
    logic                           rd_hit_reg;
    logic [CELLS-1:0]               valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_word_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
        end
    end

    // a cell never written since the last clear reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.clear_all) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

[design/dot_map_to_custom_glyph_renderer_top.sv]
// Dot map glyph renderer, top level: command sequencer and result buffering.
// Depends on dmcg_pkg and dmcg_cell_store.
//
// Usage: items arrive on s_valid/s_ready/s_data (cmd, dot_row, dot_col);
// display operations leave on m_valid/m_ready/m_data. s_ready is high only
// while the sequencer is idle; one item is handled at a time.
// Set dot / clear dot: read-modify-write of one cell word (accept, read,
// write); out-of-range positions are dropped when accepted. Clear all drops
// every cell's valid flag.
// Render: walk the used flags cell by cell, then take each scanned cell in
// turn (store read, check) until all cells are seen or the slots run out,
// then release the last operation. All store reads go through the single
// store read port.
// The first result appears once a second operation is found (or at the
// end of the walk); each result carries last on the final one.
// After reset the dot map is empty and no cell counts as used.
// A stalled receiver holds the result register; the sequencer keeps one
// further operation pending and waits there until the transfer completes.
`default_nettype none

module dot_map_to_custom_glyph_renderer_top #(
    parameter int CELL_COLUMNS = 16,
    parameter int CELL_ROWS    = 2,
    parameter int GLYPH_SLOTS  = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dmcg_pkg::dmcg_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dmcg_pkg::dmcg_out_t      m_data
);

    localparam int CELLS    = CELL_ROWS * CELL_COLUMNS;
    localparam int CELL_AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_W    = (CELL_COLUMNS > 1) ? $clog2(CELL_COLUMNS) : 1;
    localparam int ROW_DOTS = CELL_COLUMNS * dmcg_pkg::DOT_WIDTH;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DOT_RD  = 7'b0000010,
        ST_DOT_WR  = 7'b0000100,
        ST_BLANK   = 7'b0001000,
        ST_GLY_RD  = 7'b0010000,
        ST_GLY_CHK = 7'b0100000,
        ST_FLUSH   = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CELL_AW-1:0]     ci_reg, ci_next;
    logic                   row_reg, row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [3:0]             slot_reg, slot_next;
    logic [CELL_AW-1:0]     dot_addr_reg, dot_addr_next;
    logic [2:0]             dot_off_reg, dot_off_next;
    logic [7:0]             dot_mask_reg, dot_mask_next;
    logic                   dot_set_reg, dot_set_next;
    logic [CELLS-1:0]       used_reg, used_next;
    dmcg_pkg::dmcg_out_t    pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    dmcg_pkg::dmcg_out_t    out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    dmcg_pkg::dmcg_store_ctl_t      st_ctl;
    logic [CELL_AW-1:0]             st_rd_addr;
    logic [dmcg_pkg::CELL_BITS-1:0] st_wr_data;
    logic [dmcg_pkg::CELL_BITS-1:0] st_rd_data;

    logic [14:0]         dq;
    logic [4:0]          ccol;
    logic [6:0]          crem;
    logic                dot_ok;
    logic [CELL_AW-1:0]  dot_idx;
    logic [7:0]          cursor;
    logic                last_cell;
    logic                can_push;
    logic                emit_req;
    logic                emit_ok;
    logic                step;
    logic                nz;
    dmcg_pkg::dmcg_out_t new_op;

    dmcg_cell_store #(
        .CELLS (CELLS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (st_ctl),
        .rd_addr (st_rd_addr),
        .wr_addr (dot_addr_reg),
        .wr_data (st_wr_data),
        .rd_data (st_rd_data)
    );

    // dot_col / 5 by reciprocal, exact below 128
    assign dq      = 15'(s_data.dot_col) * 15'd205;
    assign ccol    = dq[14:10];
    assign crem    = s_data.dot_col - 7'(ccol) * 7'd5;
    assign dot_ok  = ({1'b0, s_data.dot_col} < 8'(ROW_DOTS))
                     && (!s_data.dot_row[3] || (CELL_ROWS > 1));
    assign dot_idx = CELL_AW'(ccol)
                     + (s_data.dot_row[3] ? CELL_AW'(CELL_COLUMNS) : CELL_AW'(0));

    assign cursor    = dmcg_pkg::CURSOR_BASE
                       | (dmcg_pkg::ROW_OFFSET[{1'b0, row_reg}] + 8'(col_reg));
    assign last_cell = (ci_reg == CELL_AW'(CELLS - 1));
    assign can_push  = !out_valid_reg || m_ready;
    assign emit_ok   = !pend_valid_reg || can_push;
    assign nz        = |st_rd_data;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next      = state_reg;
        ci_next         = ci_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        slot_next       = slot_reg;
        dot_addr_next   = dot_addr_reg;
        dot_off_next    = dot_off_reg;
        dot_mask_next   = dot_mask_reg;
        dot_set_next    = dot_set_reg;
        used_next       = used_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        st_ctl          = '0;
        st_rd_addr      = ci_reg;
        st_wr_data      = st_rd_data;
        emit_req        = 1'b0;
        step            = 1'b0;
        new_op          = '0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.cmd)
                        dmcg_pkg::CMD_SET_DOT, dmcg_pkg::CMD_CLEAR_DOT: begin
                            if (dot_ok) begin
                                dot_addr_next = dot_idx;
                                dot_off_next  = crem[2:0];
                                dot_mask_next = 8'd1 << s_data.dot_row[2:0];
                                dot_set_next  = (s_data.cmd == dmcg_pkg::CMD_SET_DOT);
                                state_next    = ST_DOT_RD;
                            end
                        end
                        dmcg_pkg::CMD_RENDER: begin
                            ci_next    = '0;
                            row_next   = 1'b0;
                            col_next   = '0;
                            slot_next  = '0;
                            state_next = ST_BLANK;
                        end
                        dmcg_pkg::CMD_CLEAR_ALL: begin
                            st_ctl.clear_all = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DOT_RD: begin
                st_ctl.rd_en = 1'b1;
                st_rd_addr   = dot_addr_reg;
                state_next   = ST_DOT_WR;
            end
            ST_DOT_WR: begin
                st_ctl.wr_en = 1'b1;
                for (int i = 0; i < dmcg_pkg::DOT_WIDTH; i++) begin
                    if (dot_off_reg == 3'(i)) begin
                        st_wr_data[8*i +: 8] = dot_set_reg
                            ? (st_rd_data[8*i +: 8] | dot_mask_reg)
                            : (st_rd_data[8*i +: 8] & ~dot_mask_reg);
                    end
                end
                state_next = ST_IDLE;
            end
            ST_BLANK: begin
                new_op.op_kind        = dmcg_pkg::OP_BLANK;
                new_op.cursor_command = cursor;
                new_op.char_code      = dmcg_pkg::BLANK_CHAR;
                emit_req              = used_reg[ci_reg];
                step                  = !used_reg[ci_reg] || emit_ok;
                if (emit_req && emit_ok) begin
                    used_next[ci_reg] = 1'b0;
                end
                if (step) begin
                    if (last_cell) begin
                        ci_next    = '0;
                        row_next   = 1'b0;
                        col_next   = '0;
                        state_next = ST_GLY_RD;
                    end else begin
                        ci_next = ci_reg + 1'b1;
                        if (col_reg == COL_W'(CELL_COLUMNS - 1)) begin
                            col_next = '0;
                            row_next = 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            ST_GLY_RD: begin
                st_ctl.rd_en = 1'b1;
                state_next   = ST_GLY_CHK;
            end
            ST_GLY_CHK: begin
                new_op.op_kind        = dmcg_pkg::OP_GLYPH;
                new_op.cursor_command = cursor;
                new_op.cgram_command  = dmcg_pkg::CGRAM_BASE
                                        | {1'b0, (slot_reg[2:0] & dmcg_pkg::SLOT_MASK), 3'b000};
                new_op.glyph_bits     = dmcg_pkg::transpose_cell(st_rd_data);
                new_op.char_code      = 8'(slot_reg);
                emit_req              = nz;
                step                  = !nz || emit_ok;
                if (emit_req && emit_ok) begin
                    used_next[ci_reg] = 1'b1;
                    slot_next         = slot_reg + 1'b1;
                end
                if (step) begin
                    if (last_cell || (nz && slot_reg == 4'(GLYPH_SLOTS - 1))) begin
                        state_next = ST_FLUSH;
                    end else begin
                        ci_next    = ci_reg + 1'b1;
                        state_next = ST_GLY_RD;
                        if (col_reg == COL_W'(CELL_COLUMNS - 1)) begin
                            col_next = '0;
                            row_next = 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (can_push) begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // hold one operation back so that last can be set on the final one
        if (emit_req && emit_ok) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_op;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            ci_reg         <= '0;
            row_reg        <= 1'b0;
            col_reg        <= '0;
            slot_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            ci_reg         <= ci_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            slot_reg       <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        dot_addr_reg <= dot_addr_next;
        dot_off_reg  <= dot_off_next;
        dot_mask_reg <= dot_mask_next;
        dot_set_reg  <= dot_set_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

[design/dmcg_checker.sv]
// Port-level checker for the dot map glyph renderer, bound to the top level.
// Depends on dmcg_pkg and the macro header.
`default_nettype none
`include "dot_map_to_custom_glyph_renderer_top_macros.svh"

module dmcg_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire dmcg_pkg::dmcg_in_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire dmcg_pkg::dmcg_out_t m_data
);

    `DMCG_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `DMCG_ASSERT_NEXT(a_render_busy, s_valid && s_ready && (s_data.cmd == dmcg_pkg::CMD_RENDER), !s_ready, "ready straight after a render transfer")
    `DMCG_ASSERT_NOW(a_blank_form, m_valid && (m_data.op_kind == dmcg_pkg::OP_BLANK), (m_data.char_code == dmcg_pkg::BLANK_CHAR) && (m_data.cgram_command == 7'd0) && (m_data.glyph_bits == '0), "malformed blank operation")
    `DMCG_ASSERT_NOW(a_glyph_form, m_valid && (m_data.op_kind == dmcg_pkg::OP_GLYPH), (m_data.char_code < 8'd8) && (m_data.cgram_command == (dmcg_pkg::CGRAM_BASE | {1'b0, m_data.char_code[2:0], 3'b000})) && (m_data.glyph_bits != '0), "glyph slot and CGRAM command disagree")

endmodule

bind dot_map_to_custom_glyph_renderer_top dmcg_checker u_dmcg_checker (.*);

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the dot map glyph renderer top level.
// Needs dmcg_pkg and dot_map_to_custom_glyph_renderer_top; a shadow dot map, or a
// directed table for some items, predicts the display operations, checked against each transfer.

module tb_top;

    localparam int CELL_COLUMNS = 16;
    localparam int CELL_ROWS    = 2;
    localparam int GLYPH_SLOTS  = 8;
    localparam int DOT_WIDTH    = dmcg_pkg::DOT_WIDTH;
    localparam int CELL_BITS    = dmcg_pkg::CELL_BITS;
    localparam int ROW_DOTS     = CELL_COLUMNS * DOT_WIDTH;
    localparam int MAP_DEPTH    = CELL_ROWS * ROW_DOTS;
    localparam int CELL_COUNT   = CELL_ROWS * CELL_COLUMNS;
    localparam int MAX_OPS      = 2 * GLYPH_SLOTS;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 3 * CELL_COUNT + 20;
    localparam int QUIET_LIMIT  = 4000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    dmcg_pkg::dmcg_in_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    dmcg_pkg::dmcg_out_t m_data;

    logic [7:0]          shadow_map [MAP_DEPTH];
    bit                  shadow_used [CELL_COUNT];
    dmcg_pkg::dmcg_out_t op_buf [MAX_OPS];
    dmcg_pkg::dmcg_out_t awaited_ops [$];
    int                  mismatches = 0;
    bit                  hold_req = 1'b0;
    int                  quiet_cycles = 0;

    dmcg_pkg::dmcg_in_t  dir_item [N_DIRECTED];
    int                  dir_n [N_DIRECTED];
    dmcg_pkg::dmcg_out_t dir_op0 [N_DIRECTED];
    dmcg_pkg::dmcg_out_t dir_op1 [N_DIRECTED];

    dot_map_to_custom_glyph_renderer_top #(
        .CELL_COLUMNS(CELL_COLUMNS),
        .CELL_ROWS   (CELL_ROWS),
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #10 aclk = ~aclk;

    function automatic dmcg_pkg::dmcg_in_t mk_item(dmcg_pkg::dmcg_cmd_t c, int row, int col);
        dmcg_pkg::dmcg_in_t it;
        it.cmd     = c;
        it.dot_row = row[3:0];
        it.dot_col = col[6:0];
        return it;
    endfunction

    function automatic logic [7:0] cursor_at(int r, int c);
        logic [7:0] cc;
        cc = c[7:0];
        return dmcg_pkg::CURSOR_BASE | (dmcg_pkg::ROW_OFFSET[r] + cc);
    endfunction

    function automatic dmcg_pkg::dmcg_out_t blank_op(logic [7:0] cursor, logic lst);
        dmcg_pkg::dmcg_out_t o;
        o.op_kind        = dmcg_pkg::OP_BLANK;
        o.cursor_command = cursor;
        o.cgram_command  = '0;
        o.glyph_bits     = '0;
        o.char_code      = dmcg_pkg::BLANK_CHAR;
        o.last           = lst;
        return o;
    endfunction

    function automatic dmcg_pkg::dmcg_out_t glyph_op(logic [7:0] cursor, int slot,
                                                     logic [CELL_BITS-1:0] glyph,
                                                     logic lst);
        dmcg_pkg::dmcg_out_t o;
        o.op_kind        = dmcg_pkg::OP_GLYPH;
        o.cursor_command = cursor;
        o.cgram_command  = dmcg_pkg::CGRAM_BASE
                           | {1'b0, slot[2:0] & dmcg_pkg::SLOT_MASK, 3'b000};
        o.glyph_bits     = glyph;
        o.char_code      = {5'b0, slot[2:0]};
        o.last           = lst;
        return o;
    endfunction

    // updates the shadow map and fills op_buf; returns the number of operations
    function automatic int run_dot_map(dmcg_pkg::dmcg_in_t it);
        int                   n;
        int                   r;
        int                   c;
        int                   i;
        int                   gr;
        int                   slot;
        int                   base;
        int                   idx;
        bit                   any;
        logic [CELL_BITS-1:0] glyph;
        n = 0;
        if (it.cmd == dmcg_pkg::CMD_SET_DOT || it.cmd == dmcg_pkg::CMD_CLEAR_DOT) begin
            if (int'(it.dot_col) < ROW_DOTS && int'(it.dot_row >> 3) < CELL_ROWS) begin
                idx = int'(it.dot_row >> 3) * ROW_DOTS + int'(it.dot_col);
                shadow_map[idx][it.dot_row[2:0]] = (it.cmd == dmcg_pkg::CMD_SET_DOT);
            end
        end else if (it.cmd == dmcg_pkg::CMD_CLEAR_ALL) begin
            for (i = 0; i < MAP_DEPTH; i++) shadow_map[i] = '0;
        end else begin
            for (r = 0; r < CELL_ROWS; r++) begin
                for (c = 0; c < CELL_COLUMNS; c++) begin
                    if (shadow_used[r*CELL_COLUMNS + c]) begin
                        op_buf[n] = blank_op(cursor_at(r, c), 1'b0);
                        n++;
                        shadow_used[r*CELL_COLUMNS + c] = 1'b0;
                    end
                end
            end
            slot = 0;
            for (r = 0; r < CELL_ROWS; r++) begin
                for (c = 0; c < CELL_COLUMNS; c++) begin
                    if (slot < GLYPH_SLOTS) begin
                        base  = r * ROW_DOTS + c * DOT_WIDTH;
                        any   = 1'b0;
                        glyph = '0;
                        for (gr = 0; gr < 8; gr++) begin
                            for (i = 0; i < DOT_WIDTH; i++) begin
                                glyph[DOT_WIDTH*gr + DOT_WIDTH - 1 - i] = shadow_map[base+i][gr];
                                if (shadow_map[base+i][gr]) any = 1'b1;
                            end
                        end
                        if (any) begin
                            op_buf[n] = glyph_op(cursor_at(r, c), slot, glyph, 1'b0);
                            n++;
                            shadow_used[r*CELL_COLUMNS + c] = 1'b1;
                            slot++;
                        end
                    end
                end
            end
            if (n > 0) op_buf[n-1].last = 1'b1;
        end
        return n;
    endfunction

    // drive one item until its transfer; tab_idx >= 0 selects a directed row
    task automatic send_item(dmcg_pkg::dmcg_in_t it, int tab_idx);
        int n;
        int k;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        n = run_dot_map(it);
        if (tab_idx >= 0 && dir_n[tab_idx] >= 0) begin
            if (dir_n[tab_idx] > 0) awaited_ops.push_back(dir_op0[tab_idx]);
            if (dir_n[tab_idx] > 1) awaited_ops.push_back(dir_op1[tab_idx]);
        end else begin
            for (k = 0; k < n; k++) awaited_ops.push_back(op_buf[k]);
        end
    endtask

    task automatic sender_gap(int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_ops.size() != 0) @(posedge aclk);
    endtask

    task automatic check_op(dmcg_pkg::dmcg_out_t got);
        dmcg_pkg::dmcg_out_t exp_op;
        if (awaited_ops.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transfer: kind %0d cursor %h cgram %h glyph %h code %h last %0d",
                         got.op_kind, got.cursor_command, got.cgram_command,
                         got.glyph_bits, got.char_code, got.last);
        end else begin
            exp_op = awaited_ops.pop_front();
            if (got.op_kind !== exp_op.op_kind || got.cursor_command !== exp_op.cursor_command ||
                got.cgram_command !== exp_op.cgram_command ||
                got.glyph_bits !== exp_op.glyph_bits ||
                got.char_code !== exp_op.char_code || got.last !== exp_op.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp: kind %0d cursor %h cgram %h glyph %h code %h last %0d",
                             exp_op.op_kind, exp_op.cursor_command, exp_op.cgram_command,
                             exp_op.glyph_bits, exp_op.char_code, exp_op.last);
                    $display("         got: kind %0d cursor %h cgram %h glyph %h code %h last %0d",
                             got.op_kind, got.cursor_command, got.cgram_command,
                             got.glyph_bits, got.char_code, got.last);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_op(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // receiver: modes of always-ready, rotating pattern and random stalls, plus one long hold on request
    initial begin
        int         mode;
        int         mode_left;
        int         hold_cnt;
        logic [7:0] pattern;
        mode      = 0;
        mode_left = 0;
        pattern   = 8'hff;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_cnt++;
                end
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                    pattern   = 8'($urandom);
                end
                mode_left--;
                if (mode == 0) m_ready <= 1'b1;
                else if (mode == 1) m_ready <= pattern[0];
                else m_ready <= ($urandom_range(0, 3) != 0);
                pattern = {pattern[0], pattern[7:1]};
            end
        end
    end

    initial begin
        int                  i;
        int                  k;
        int                  pick;
        int                  burst_left;
        int                  gap;
        dmcg_pkg::dmcg_cmd_t c;
        dmcg_pkg::dmcg_in_t  it;

        for (i = 0; i < MAP_DEPTH; i++) shadow_map[i] = '0;
        for (i = 0; i < CELL_COUNT; i++) shadow_used[i] = 1'b0;
        for (i = 0; i < N_DIRECTED; i++) dir_n[i] = -1;

        // empty render after reset
        dir_item[0]  = mk_item(dmcg_pkg::CMD_RENDER, 0, 0);
        dir_n[0]     = 0;
        dir_item[1]  = mk_item(dmcg_pkg::CMD_SET_DOT, 0, 0);
        dir_item[2]  = mk_item(dmcg_pkg::CMD_RENDER, 15, 127);
        dir_n[2]     = 1;
        dir_op0[2]   = glyph_op(8'h80, 0, 40'h0000000010, 1'b1);
        dir_item[3]  = mk_item(dmcg_pkg::CMD_RENDER, 0, 0);
        dir_n[3]     = 2;
        dir_op0[3]   = blank_op(8'h80, 1'b0);
        dir_op1[3]   = glyph_op(8'h80, 0, 40'h0000000010, 1'b1);
        dir_item[4]  = mk_item(dmcg_pkg::CMD_SET_DOT, 15, 79);
        dir_item[5]  = mk_item(dmcg_pkg::CMD_CLEAR_DOT, 0, 0);
        // columns past the map are dropped
        dir_item[6]  = mk_item(dmcg_pkg::CMD_SET_DOT, 3, 80);
        dir_item[7]  = mk_item(dmcg_pkg::CMD_SET_DOT, 15, 127);
        dir_item[8]  = mk_item(dmcg_pkg::CMD_RENDER, 0, 0);
        dir_n[8]     = 2;
        dir_op0[8]   = blank_op(8'h80, 1'b0);
        dir_op1[8]   = glyph_op(8'hcf, 0, 40'h0800000000, 1'b1);
        // clear all keeps the used cells
        dir_item[9]  = mk_item(dmcg_pkg::CMD_CLEAR_ALL, 15, 127);
        dir_item[10] = mk_item(dmcg_pkg::CMD_RENDER, 0, 0);
        dir_n[10]    = 1;
        dir_op0[10]  = blank_op(8'hcf, 1'b1);
        dir_item[11] = mk_item(dmcg_pkg::CMD_RENDER, 0, 0);
        dir_n[11]    = 0;
        // nine busy cells, more than there are slots
        for (k = 0; k < 9; k++)
            dir_item[12+k] = mk_item(dmcg_pkg::CMD_SET_DOT, (k % 2) ? 8 : 7, 5*k + k % 5);
        dir_item[21] = mk_item(dmcg_pkg::CMD_RENDER, 0, 0);
        dir_item[22] = mk_item(dmcg_pkg::CMD_RENDER, 9, 33);
        dir_item[23] = mk_item(dmcg_pkg::CMD_CLEAR_ALL, 0, 0);
        dir_item[24] = mk_item(dmcg_pkg::CMD_RENDER, 0, 0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        burst_left = 0;
        for (i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) sender_gap(gap);
            end
            burst_left--;
            if (i == N_DIRECTED + 100) hold_req = 1'b1;
            if (i == N_DIRECTED + 200) wait_drained();
            if (i < N_DIRECTED) begin
                send_item(dir_item[i], i);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) c = dmcg_pkg::CMD_SET_DOT;
                else if (pick < 70) c = dmcg_pkg::CMD_CLEAR_DOT;
                else if (pick < 88) c = dmcg_pkg::CMD_RENDER;
                else if (pick < 92) c = dmcg_pkg::CMD_CLEAR_ALL;
                else c = dmcg_pkg::CMD_SET_DOT;
                it = mk_item(c, $urandom_range(0, 15),
                             ($urandom_range(0, 9) == 0 || pick >= 92) ?
                             $urandom_range(0, 127) : $urandom_range(0, ROW_DOTS - 1));
                send_item(it, -1);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && awaited_ops.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/dmcg_pkg.sv
design/dmcg_cell_store.sv
design/dot_map_to_custom_glyph_renderer_top.sv
design/dmcg_checker.sv
tb/sv/tb_top.sv
